// ----- hw/rtl/itil_pkg.sv -----
// Shared types and constants for the inverse table interpolating lookup.
package itil_pkg;

    // Payload widths
    localparam int FREQ_W  = 22;
    localparam int INDEX_W = 8;
    localparam int DUTY_W  = 8;
    localparam int KIND_W  = 2;

    // Default table depth
    localparam int TABLE_ENTRIES_DEF = 256;

    // Full-scale duty
    localparam logic [DUTY_W-1:0] DUTY_FULL = 8'd255;

    // Request command codes
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Result classification
    typedef enum logic [KIND_W-1:0] {
        KIND_INTERP = 2'd0,
        KIND_EXACT  = 2'd1,
        KIND_BELOW  = 2'd2,
        KIND_ABOVE  = 2'd3
    } match_kind_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH_RD,
        S_SEARCH_CMP,
        S_FOUND_RD,
        S_FOUND_CMP,
        S_PAIR_RD,
        S_PAIR_CMP,
        S_MUL_LO,
        S_MUL_DEN,
        S_SCALE,
        S_DIV,
        S_FINISH
    } itil_state_t;

endpackage

// ----- hw/rtl/itil_req_if.sv -----
// Request channel: table writes and frequency lookups.
interface itil_req_if;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [itil_pkg::INDEX_W-1:0] entry_index;
    logic [itil_pkg::FREQ_W-1:0]  frequency;

    modport source (output valid, output command, output entry_index, output frequency,
                    input ready);
    modport sink   (input valid, input command, input entry_index, input frequency,
                    output ready);
endinterface

// ----- hw/rtl/itil_rsp_if.sv -----
// Response channel: duty result and match classification.
interface itil_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [itil_pkg::DUTY_W-1:0] duty;
    logic [itil_pkg::KIND_W-1:0] match_kind;

    modport source (output valid, output duty, output match_kind, input ready);
    modport sink   (input valid, input duty, input match_kind, output ready);
endinterface

// ----- hw/rtl/inverse_table_interp_lookup.sv -----
// Top level: calibration table with binary search and interpolated inverse lookup.
//
//   channel | dir | payload                                | completes when
//   --------+-----+----------------------------------------+------------------
//   req     | in  | command, entry_index, frequency        | valid && ready
//   rsp     | out | duty, match_kind                       | valid && ready
//
// A write request gives no response. A lookup reads the table once per search
// step on the single table read port, then makes one or two more table reads;
// a query inside the table range then takes two products on one shared multiplier
// and a nine-step restoring divider, which may end early on clamp.
// req.ready is high only while the sequencer is idle. A finished response waits
// in the output register while the next request is accepted; a second lookup
// stalls at its last step until that register is taken. Reset clears the
// sequencer and response valid; the table is undefined until written.
module inverse_table_interp_lookup #(
    parameter int TABLE_ENTRIES = itil_pkg::TABLE_ENTRIES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    itil_req_if.sink  req,
    itil_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int EXT_W = (IDX_W > itil_pkg::INDEX_W) ? IDX_W : itil_pkg::INDEX_W;
    localparam int MA_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int P_W   = MA_W + itil_pkg::FREQ_W;
    localparam int T_W   = P_W + 2;
    localparam int R_W   = T_W + itil_pkg::DUTY_W;
    localparam int CNT_W = $clog2(itil_pkg::DUTY_W + 1);
    localparam int FW    = itil_pkg::FREQ_W;
    localparam int DW    = itil_pkg::DUTY_W;

    // Sequencer and response state
    itil_pkg::itil_state_t state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;
    logic [DW-1:0]         out_duty_reg, out_duty_next;
    itil_pkg::match_kind_t out_kind_reg, out_kind_next;

    // Datapath registers
    logic [FW-1:0]         q_reg, q_next;
    logic [IDX_W-1:0]      a_reg, a_next;
    logic [IDX_W-1:0]      b_reg, b_next;
    logic [IDX_W-1:0]      c_reg, c_next;
    logic [IDX_W-1:0]      lo_reg, lo_next;
    logic [FW-1:0]         f_known_reg, f_known_next;
    logic                  known_is_hi_reg, known_is_hi_next;
    logic [FW-1:0]         d_reg, d_next;
    logic signed [FW:0]    e_reg, e_next;
    logic [P_W-1:0]        prod_reg, prod_next;
    logic [P_W-1:0]        den_reg, den_next;
    logic signed [T_W-1:0] t_reg, t_next;
    logic [R_W-1:0]        rem_reg, rem_next;
    logic [R_W-1:0]        dsh_reg, dsh_next;
    logic [DW-1:0]         quot_reg, quot_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DW-1:0]         duty_res_reg, duty_res_next;
    itil_pkg::match_kind_t kind_reg, kind_next;

    // Table RAM port signals
    logic             ram_wr_en;
    logic [IDX_W-1:0] ram_wr_addr;
    logic             ram_rd_en;
    logic [IDX_W-1:0] ram_rd_addr;
    logic [FW-1:0]    ram_rd_data;

    // Combinational helpers
    logic [EXT_W-1:0] wr_idx_ext;
    logic             wr_in_range;
    logic [IDX_W:0]   mid_sum;
    logic [IDX_W-1:0] mid_idx;
    logic             search_lt;
    logic [IDX_W-1:0] a_srch, b_srch, span;
    logic [FW-1:0]    flo, fhi;
    logic [MA_W-1:0]  mul_a;
    logic [P_W-1:0]   mul_out;
    logic [R_W-1:0]   t_ext;
    logic             div_ge;
    logic [DW-1:0]    quot_shift;

    itil_ram #(
        .WIDTH (FW),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (req.frequency),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Write address and range check
    assign wr_idx_ext  = EXT_W'(req.entry_index);
    assign ram_wr_addr = wr_idx_ext[IDX_W-1:0];
    assign wr_in_range = 32'(req.entry_index) < 32'(TABLE_ENTRIES);

    // Search step: midpoint and bracket update
    assign mid_sum   = {1'b0, a_reg} + {1'b0, b_reg};
    assign mid_idx   = mid_sum[IDX_W:1];
    assign search_lt = q_reg < ram_rd_data;
    assign a_srch    = search_lt ? a_reg : c_reg;
    assign b_srch    = search_lt ? c_reg : b_reg;
    assign span      = b_srch - a_srch;

    // Bracketing pair, one entry held and one just read
    assign flo = known_is_hi_reg ? ram_rd_data : f_known_reg;
    assign fhi = known_is_hi_reg ? f_known_reg : ram_rd_data;

    // Shared multiplier: lo*d, then entries*d
    assign mul_a   = (state_reg == itil_pkg::S_MUL_DEN) ? MA_W'(TABLE_ENTRIES) : MA_W'(lo_reg);
    assign mul_out = mul_a * d_reg;

    // Divider step
    assign t_ext      = R_W'($unsigned(t_reg));
    assign div_ge     = rem_reg >= dsh_reg;
    assign quot_shift = {quot_reg[DW-2:0], div_ge};

    // Response channel
    assign req.ready      = (state_reg == itil_pkg::S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.duty       = out_duty_reg;
    assign rsp.match_kind = out_kind_reg;

    // Next state and datapath control
    always_comb
    begin
        state_next       = state_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_duty_next    = out_duty_reg;
        out_kind_next    = out_kind_reg;
        q_next           = q_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        c_next           = c_reg;
        lo_next          = lo_reg;
        f_known_next     = f_known_reg;
        known_is_hi_next = known_is_hi_reg;
        d_next           = d_reg;
        e_next           = e_reg;
        prod_next        = prod_reg;
        den_next         = den_reg;
        t_next           = t_reg;
        rem_next         = rem_reg;
        dsh_next         = dsh_reg;
        quot_next        = quot_reg;
        cnt_next         = cnt_reg;
        duty_res_next    = duty_res_reg;
        kind_next        = kind_reg;
        ram_wr_en        = 1'b0;
        ram_rd_en        = 1'b0;
        ram_rd_addr      = a_reg;

        case (state_reg)
            itil_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    q_next = req.frequency;
                    if (req.command == itil_pkg::CMD_LOOKUP)
                    begin
                        a_next     = '0;
                        b_next     = IDX_W'(TABLE_ENTRIES - 1);
                        state_next = itil_pkg::S_SEARCH_RD;
                    end
                    else
                    begin
                        ram_wr_en = wr_in_range;
                    end
                end
            end

            itil_pkg::S_SEARCH_RD:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = mid_idx;
                c_next      = mid_idx;
                state_next  = itil_pkg::S_SEARCH_CMP;
            end

            itil_pkg::S_SEARCH_CMP:
            begin
                a_next = a_srch;
                b_next = b_srch;
                if (span > IDX_W'(1))
                begin
                    state_next = itil_pkg::S_SEARCH_RD;
                end
                else
                begin
                    state_next = itil_pkg::S_FOUND_RD;
                end
            end

            itil_pkg::S_FOUND_RD:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = a_reg;
                state_next  = itil_pkg::S_FOUND_CMP;
            end

            itil_pkg::S_FOUND_CMP:
            begin
                if (q_reg == ram_rd_data)
                begin
                    // exact hit: scale the index alone (d = 1, e = 0)
                    lo_next    = a_reg;
                    d_next     = FW'(1);
                    e_next     = '0;
                    kind_next  = itil_pkg::KIND_EXACT;
                    state_next = itil_pkg::S_MUL_LO;
                end
                else if (q_reg < ram_rd_data)
                begin
                    if (a_reg == '0)
                    begin
                        duty_res_next = '0;
                        kind_next     = itil_pkg::KIND_BELOW;
                        state_next    = itil_pkg::S_FINISH;
                    end
                    else
                    begin
                        lo_next          = a_reg - IDX_W'(1);
                        f_known_next     = ram_rd_data;
                        known_is_hi_next = 1'b1;
                        state_next       = itil_pkg::S_PAIR_RD;
                    end
                end
                else
                begin
                    if (32'(a_reg) + 32'd1 >= 32'(TABLE_ENTRIES))
                    begin
                        duty_res_next = itil_pkg::DUTY_FULL;
                        kind_next     = itil_pkg::KIND_ABOVE;
                        state_next    = itil_pkg::S_FINISH;
                    end
                    else
                    begin
                        lo_next          = a_reg;
                        f_known_next     = ram_rd_data;
                        known_is_hi_next = 1'b0;
                        state_next       = itil_pkg::S_PAIR_RD;
                    end
                end
            end

            itil_pkg::S_PAIR_RD:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = known_is_hi_reg ? lo_reg : (lo_reg + IDX_W'(1));
                state_next  = itil_pkg::S_PAIR_CMP;
            end

            itil_pkg::S_PAIR_CMP:
            begin
                kind_next = itil_pkg::KIND_INTERP;
                // slope magnitude and offset, sign folded into the offset
                if (fhi == flo)
                begin
                    d_next = FW'(1);
                    e_next = '0;
                end
                else if (fhi > flo)
                begin
                    d_next = fhi - flo;
                    e_next = $signed({1'b0, q_reg}) - $signed({1'b0, flo});
                end
                else
                begin
                    d_next = flo - fhi;
                    e_next = $signed({1'b0, flo}) - $signed({1'b0, q_reg});
                end
                state_next = itil_pkg::S_MUL_LO;
            end

            itil_pkg::S_MUL_LO:
            begin
                prod_next  = mul_out;
                state_next = itil_pkg::S_MUL_DEN;
            end

            itil_pkg::S_MUL_DEN:
            begin
                den_next   = mul_out;
                t_next     = $signed({2'b00, prod_reg}) + T_W'(e_reg);
                state_next = itil_pkg::S_SCALE;
            end

            itil_pkg::S_SCALE:
            begin
                if (t_reg < 0)
                begin
                    duty_res_next = '0;
                    state_next    = itil_pkg::S_FINISH;
                end
                else
                begin
                    // numerator t*255, divisor entries*d aligned for 9 quotient bits
                    rem_next   = (t_ext << DW) - t_ext;
                    dsh_next   = R_W'(den_reg) << DW;
                    cnt_next   = CNT_W'(DW);
                    quot_next  = '0;
                    state_next = itil_pkg::S_DIV;
                end
            end

            itil_pkg::S_DIV:
            begin
                if (div_ge)
                begin
                    rem_next = rem_reg - dsh_reg;
                end
                quot_next = quot_shift;
                dsh_next  = dsh_reg >> 1;
                cnt_next  = cnt_reg - CNT_W'(1);
                if ((cnt_reg == CNT_W'(DW)) && div_ge)
                begin
                    // quotient reaches 256: clamp
                    duty_res_next = itil_pkg::DUTY_FULL;
                    state_next    = itil_pkg::S_FINISH;
                end
                else if (cnt_reg == '0)
                begin
                    duty_res_next = quot_shift;
                    state_next    = itil_pkg::S_FINISH;
                end
            end

            itil_pkg::S_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_duty_next  = duty_res_reg;
                    out_kind_next  = kind_reg;
                    state_next     = itil_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = itil_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= itil_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        out_duty_reg    <= out_duty_next;
        out_kind_reg    <= out_kind_next;
        q_reg           <= q_next;
        a_reg           <= a_next;
        b_reg           <= b_next;
        c_reg           <= c_next;
        lo_reg          <= lo_next;
        f_known_reg     <= f_known_next;
        known_is_hi_reg <= known_is_hi_next;
        d_reg           <= d_next;
        e_reg           <= e_next;
        prod_reg        <= prod_next;
        den_reg         <= den_next;
        t_reg           <= t_next;
        rem_reg         <= rem_next;
        dsh_reg         <= dsh_next;
        quot_reg        <= quot_next;
        cnt_reg         <= cnt_next;
        duty_res_reg    <= duty_res_next;
        kind_reg        <= kind_next;
    end

endmodule

// ----- hw/rtl/itil_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module itil_ram #(
    parameter int WIDTH = itil_pkg::FREQ_W,
    parameter int DEPTH = itil_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
